>>> design/pmon_pkg.sv
// ----------------------------------------------------------------------------
// pmon_pkg: shared types and constants of the pedal plausibility monitor
// Holds the configuration record, the queue entry and the fixed thresholds.
// ----------------------------------------------------------------------------
`default_nettype none

package pmon_pkg;

  // Field widths fixed by the interface.
  localparam int MV_W      = 13;
  localparam int FRAC_W    = 17;
  localparam int QUO_W     = 16;
  localparam int CNT_W     = 8;
  localparam int CFG_W     = 17;
  localparam int CFG_IDX_W = 3;

  // Fixed thresholds.
  localparam logic [MV_W-1:0]   OPEN_WIRE_MV   = MV_W'(150);
  localparam logic [FRAC_W-1:0] FRAC_ONE       = FRAC_W'(65536);
  localparam logic [FRAC_W-1:0] BRAKE_THR_FRAC = FRAC_W'(16384);
  localparam logic [FRAC_W-1:0] RELEASE_FRAC   = FRAC_W'(3276);
  localparam logic [CNT_W-1:0]  COUNT_MAX      = CNT_W'(255);

  // Register indexes of the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_P1_REST  = 3'd0,
    CFG_P1_FULL  = 3'd1,
    CFG_P2_REST  = 3'd2,
    CFG_P2_FULL  = 3'd3,
    CFG_GAP      = 3'd4,
    CFG_BRAKE    = 3'd5,
    CFG_DEBOUNCE = 3'd6
  } pmon_cfg_idx_t;

  // Register reset values.
  localparam logic [MV_W-1:0]   RST_P1_REST  = MV_W'(2076);
  localparam logic [MV_W-1:0]   RST_P1_FULL  = MV_W'(950);
  localparam logic [MV_W-1:0]   RST_P2_REST  = MV_W'(2672);
  localparam logic [MV_W-1:0]   RST_P2_FULL  = MV_W'(3750);
  localparam logic [FRAC_W-1:0] RST_GAP      = FRAC_W'(6554);
  localparam logic [MV_W-1:0]   RST_BRAKE    = MV_W'(1000);
  localparam logic [CNT_W-1:0]  RST_DEBOUNCE = CNT_W'(10);

  typedef struct packed {
    logic [MV_W-1:0]   p1_rest;
    logic [MV_W-1:0]   p1_full;
    logic [MV_W-1:0]   p2_rest;
    logic [MV_W-1:0]   p2_full;
    logic [FRAC_W-1:0] gap_limit;
    logic [MV_W-1:0]   brake_limit;
    logic [CNT_W-1:0]  debounce;
  } pmon_cfg_t;

  // One pedal sensor after classification: fraction is zero, saturated,
  // or the quotient of an / ad with an below ad.
  typedef struct packed {
    logic            zero;
    logic            sat;
    logic [MV_W-1:0] an;
    logic [MV_W-1:0] ad;
  } pmon_pedal_t;

  // Queue entry between the front and the back.
  typedef struct packed {
    pmon_pedal_t p1;
    pmon_pedal_t p2;
    logic        open_wire;
    logic        brake_on;
  } pmon_item_t;

endpackage

`default_nettype wire

>>> design/pmon_front.sv
// ----------------------------------------------------------------------------
// pmon_front: input classification
// Accepts an item, works out sign, magnitude and saturation of each pedal
// fraction, the open wire check and the brake check, and queues the result.
// ----------------------------------------------------------------------------
`default_nettype none

module pmon_front
  import pmon_pkg::*;
(
  input  wire logic [MV_W-1:0] pedal1_mv,
  input  wire logic [MV_W-1:0] pedal2_mv,
  input  wire logic [MV_W-1:0] brake1_mv,
  input  wire logic [MV_W-1:0] brake2_mv,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire pmon_cfg_t       cfg,
  input  wire logic            q_full,
  output logic                 q_push,
  output pmon_item_t           q_data
);

  // Signed offset from rest for one sensor, and its classification.
  function automatic pmon_pedal_t classify(input logic [MV_W-1:0] v,
                                           input logic [MV_W-1:0] rest,
                                           input logic [MV_W-1:0] full);
    logic signed [MV_W:0] num;
    logic signed [MV_W:0] den;
    logic [MV_W:0]        an_w;
    logic [MV_W:0]        ad_w;
    pmon_pedal_t          p;
    num    = $signed({1'b0, v}) - $signed({1'b0, rest});
    den    = $signed({1'b0, full}) - $signed({1'b0, rest});
    an_w   = num[MV_W] ? (MV_W+1)'(-num) : num;
    ad_w   = den[MV_W] ? (MV_W+1)'(-den) : den;
    p.an   = an_w[MV_W-1:0];
    p.ad   = ad_w[MV_W-1:0];
    p.zero = (den == '0) || (num == '0) || (num[MV_W] != den[MV_W]);
    p.sat  = (p.an >= p.ad);
    return p;
  endfunction

  logic [MV_W:0] brake_sum;

  // The queue takes a new item whenever it has room.
  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  // Classification of the item on the input ports.
  assign brake_sum = {1'b0, brake1_mv} + {1'b0, brake2_mv};

  always_comb begin
    q_data.p1        = classify(pedal1_mv, cfg.p1_rest, cfg.p1_full);
    q_data.p2        = classify(pedal2_mv, cfg.p2_rest, cfg.p2_full);
    q_data.open_wire = (pedal1_mv <= OPEN_WIRE_MV) || (pedal2_mv <= OPEN_WIRE_MV);
    q_data.brake_on  = (brake_sum >= {cfg.brake_limit, 1'b0});
  end

endmodule

`default_nettype wire

>>> design/pmon_fifo.sv
// ----------------------------------------------------------------------------
// pmon_fifo: short queue between front and back
// Register based first-in first-out queue with combinational read of the head.
// ----------------------------------------------------------------------------
`default_nettype none

module pmon_fifo #(
  parameter int WIDTH = 58,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      rd_data,
  output logic                  full,
  output logic                  empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;

  assign full    = (fill == CNT_W'(DEPTH));
  assign empty   = (fill == '0);
  assign rd_data = slots[rd_ptr];

  // Pointers wrap at the depth, which need not be a power of two.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  // Storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  // The back must never take an item from an empty queue.
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst) empty |-> !pop)
    else $error("item taken from an empty queue");

  // The fill level follows the handshakes of the previous cycle.
  a_fill_track: assert property (@(posedge clk) disable iff (rst)
    (push && !pop && !full) |=> (fill == $past(fill) + 1'b1))
    else $error("queue fill level lost an item");

endmodule

`default_nettype wire

>>> design/pmon_back.sv
// ----------------------------------------------------------------------------
// pmon_back: fraction division, plausibility state and result register
// Divides both pedal fractions in turn on one radix-4 restoring divider,
// then updates the debounce counter and fault latch and presents the result.
// ----------------------------------------------------------------------------
`default_nettype none

module pmon_back
  import pmon_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire pmon_cfg_t         cfg,
  input  wire logic              q_empty,
  input  wire pmon_item_t        q_data,
  output logic                   q_pop,
  output logic [FRAC_W-1:0]      throttle_frac,
  output logic                   fault_latched,
  output logic [CNT_W-1:0]       implausible_ticks,
  output logic                   out_valid,
  input  wire logic              out_ready
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_DIV  = 4'b0010,
    S_GAP  = 4'b0100,
    S_UPD  = 4'b1000
  } state_t;

  localparam int STEP_W = $clog2(QUO_W / 2);

  state_t            state, state_next;
  pmon_item_t        item;
  logic              sel;
  logic [STEP_W-1:0] step;
  logic [MV_W-1:0]   rem;
  logic [QUO_W-1:0]  quo;
  logic [FRAC_W-1:0] f1;
  logic [FRAC_W-1:0] f2;
  logic [FRAC_W-1:0] lo;
  logic              gap_hit;
  logic [CNT_W-1:0]  count;
  logic              fault;

  pmon_pedal_t       pc;
  logic [MV_W:0]     r1s, r2s;
  logic [MV_W-1:0]   r1, r2;
  logic              ge1, ge2;
  logic [QUO_W-1:0]  quo_next;
  logic [FRAC_W-1:0] frac;
  logic              last_step;
  logic              slot_free;
  logic [FRAC_W-1:0] hi_c, lo_c;
  logic [CNT_W-1:0]  cnt_next;
  logic              flt_next;
  logic              flt_set;

  // Sensor currently in the divider.
  assign pc = sel ? item.p2 : item.p1;

  // Two restoring steps a cycle; for a sensor that is neither zero nor saturated the remainder stays below the divisor.
  always_comb begin
    r1s      = {rem, 1'b0};
    ge1      = (r1s >= {1'b0, pc.ad});
    r1       = ge1 ? MV_W'(r1s - {1'b0, pc.ad}) : r1s[MV_W-1:0];
    r2s      = {r1, 1'b0};
    ge2      = (r2s >= {1'b0, pc.ad});
    r2       = ge2 ? MV_W'(r2s - {1'b0, pc.ad}) : r2s[MV_W-1:0];
    quo_next = {quo[QUO_W-3:0], ge1, ge2};
    if (pc.zero) begin
      frac = '0;
    end else if (pc.sat) begin
      frac = FRAC_ONE;
    end else begin
      frac = {1'b0, quo_next};
    end
  end

  assign last_step = (step == STEP_W'(QUO_W / 2 - 1));
  assign slot_free = !out_valid || out_ready;
  assign q_pop     = (state == S_IDLE) && !q_empty;

  // Smaller and larger fraction.
  always_comb begin
    if (f1 < f2) begin
      lo_c = f1;
      hi_c = f2;
    end else begin
      lo_c = f2;
      hi_c = f1;
    end
  end

  // Counter and latch update in the order the checks take effect. A latch
  // that is set at any point in the tick zeroes the throttle, even when the
  // recovery check clears it again at the end.
  always_comb begin
    cnt_next = count;
    flt_next = fault;
    if (item.open_wire) begin
      flt_next = 1'b1;
    end else if (gap_hit) begin
      cnt_next = (count == COUNT_MAX) ? count : count + 1'b1;
      if (cnt_next >= cfg.debounce) begin
        flt_next = 1'b1;
      end
    end else begin
      cnt_next = '0;
    end
    if (item.brake_on && !flt_next && (lo > BRAKE_THR_FRAC)) begin
      flt_next = 1'b1;
    end
    flt_set = flt_next;
    if (flt_next && (lo <= RELEASE_FRAC) && (cnt_next == '0)) begin
      flt_next = 1'b0;
    end
  end

  // Sequencer.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (!q_empty) begin
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        if (last_step && sel) begin
          state_next = S_GAP;
        end
      end
      S_GAP: begin
        state_next = S_UPD;
      end
      S_UPD: begin
        if (slot_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      fault     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_UPD && slot_free) begin
        count     <= cnt_next;
        fault     <= flt_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        item <= q_data;
        sel  <= 1'b0;
        step <= '0;
        rem  <= (q_data.p1.zero || q_data.p1.sat) ? '0 : q_data.p1.an;
      end
      S_DIV: begin
        quo <= quo_next;
        if (last_step && !sel) begin
          // First fraction done: load the second sensor.
          f1   <= frac;
          sel  <= 1'b1;
          step <= '0;
          rem  <= (item.p2.zero || item.p2.sat) ? '0 : item.p2.an;
        end else begin
          rem  <= r2;
          step <= step + 1'b1;
          if (last_step) begin
            f2 <= frac;
          end
        end
      end
      S_GAP: begin
        lo      <= lo_c;
        gap_hit <= (FRAC_W'(hi_c - lo_c) >= cfg.gap_limit);
      end
      S_UPD: begin
        if (slot_free) begin
          throttle_frac     <= flt_set ? '0 : lo;
          fault_latched     <= flt_next;
          implausible_ticks <= cnt_next;
        end
      end
      default: begin
      end
    endcase
  end

  // The divider keeps its remainder below the divisor.
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV && !pc.zero && !pc.sat) |-> (rem < pc.ad))
    else $error("divider remainder out of range");

  // A result is written as soon as the output slot frees up.
  a_result_out: assert property (@(posedge clk) disable iff (rst)
    (state == S_UPD && slot_free) |=> (out_valid && state == S_IDLE))
    else $error("result not presented");

  // While the latch is set the throttle is zero.
  a_latched_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && fault_latched) |-> (throttle_frac == '0))
    else $error("throttle not zero under a latched fault");

  // A waiting result is not overwritten.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(throttle_frac)
                                   && $stable(implausible_ticks)))
    else $error("waiting result overwritten");

endmodule

`default_nettype wire

>>> design/pedal_plausibility_monitor.sv
// ----------------------------------------------------------------------------
// pedal_plausibility_monitor: accelerator pedal plausibility check
// Maps two pedal sensors to travel fractions, checks them against each other
// and against the brake, and keeps a debounced fault latch.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake            Fields
//   in       input      in_valid/in_ready    pedal1_mv pedal2_mv brake1_mv brake2_mv
//   out      output     out_valid/out_ready  throttle_frac fault_latched
//                                            implausible_ticks
//   cfg      input      cfg_we               cfg_index cfg_data
//
// An item passes through the back part in this order: a load, the two
// fraction divisions on the shared radix-4 divider one after the other, the
// gap compare and the latch update. The queue holds QUEUE_DEPTH items, so the
// input keeps accepting while the back works or a result waits, until the
// queue is full. Reset clears the queue, the counter, the latch and the output
// valid, and loads the register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module pedal_plausibility_monitor
  import pmon_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [MV_W-1:0]      pedal1_mv,
  input  wire logic [MV_W-1:0]      pedal2_mv,
  input  wire logic [MV_W-1:0]      brake1_mv,
  input  wire logic [MV_W-1:0]      brake2_mv,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [FRAC_W-1:0]         throttle_frac,
  output logic                      fault_latched,
  output logic [CNT_W-1:0]          implausible_ticks,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data
);

  pmon_cfg_t  cfg;
  pmon_item_t push_item;
  pmon_item_t head_item;
  logic       q_push, q_pop, q_full, q_empty;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.p1_rest     <= RST_P1_REST;
      cfg.p1_full     <= RST_P1_FULL;
      cfg.p2_rest     <= RST_P2_REST;
      cfg.p2_full     <= RST_P2_FULL;
      cfg.gap_limit   <= RST_GAP;
      cfg.brake_limit <= RST_BRAKE;
      cfg.debounce    <= RST_DEBOUNCE;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_P1_REST:  cfg.p1_rest     <= cfg_data[MV_W-1:0];
        CFG_P1_FULL:  cfg.p1_full     <= cfg_data[MV_W-1:0];
        CFG_P2_REST:  cfg.p2_rest     <= cfg_data[MV_W-1:0];
        CFG_P2_FULL:  cfg.p2_full     <= cfg_data[MV_W-1:0];
        CFG_GAP:      cfg.gap_limit   <= cfg_data[FRAC_W-1:0];
        CFG_BRAKE:    cfg.brake_limit <= cfg_data[MV_W-1:0];
        CFG_DEBOUNCE: cfg.debounce    <= cfg_data[CNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Front part: classification and queue push.
  pmon_front u_front (
    .pedal1_mv (pedal1_mv),
    .pedal2_mv (pedal2_mv),
    .brake1_mv (brake1_mv),
    .brake2_mv (brake2_mv),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .cfg       (cfg),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_data    (push_item)
  );

  // Queue between the two parts.
  pmon_fifo #(
    .WIDTH ($bits(pmon_item_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .wr_data (push_item),
    .pop     (q_pop),
    .rd_data (head_item),
    .full    (q_full),
    .empty   (q_empty)
  );

  // Back part: division, plausibility state and result.
  pmon_back u_back (
    .clk               (clk),
    .rst               (rst),
    .cfg               (cfg),
    .q_empty           (q_empty),
    .q_data            (head_item),
    .q_pop             (q_pop),
    .throttle_frac     (throttle_frac),
    .fault_latched     (fault_latched),
    .implausible_ticks (implausible_ticks),
    .out_valid         (out_valid),
    .out_ready         (out_ready)
  );

endmodule

`default_nettype wire
